@@ rtl/core/first_fit_heap_allocator_macros.svh @@
// Assertion helpers shared by the allocator RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FFHA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FFHA_ASSERT_NEXT(name, ante, cons, msg) \
  `FFHA_ASSERT(name, (ante) |=> (cons), msg)

`endif

@@ rtl/core/ffha_pkg.sv @@
package ffha_pkg;

  localparam int unsigned HEAP_GRANULES = 4096;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned GRAN_W        = $clog2(HEAP_GRANULES);
  localparam int unsigned GRAN_W1       = GRAN_W + 1;
  localparam int unsigned GOFF_W        = $clog2(GRANULE_BYTES);
  localparam int unsigned BYTE_W        = 16;
  localparam int unsigned STATUS_W      = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_OOM          = 3'd1,
    ST_NULL         = 3'd2,
    ST_NOT_BLOCK    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  // One header word per granule.
  typedef struct packed {
    logic              mark;
    logic              used;
    logic [GRAN_W-1:0] len;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  // Accesses issued by the sequencer to the header and back-link memories.
  typedef struct packed {
    logic [GRAN_W-1:0] rd_addr;
    logic              hdr_we;
    logic [GRAN_W-1:0] hdr_addr;
    hdr_t              hdr_data;
    logic              prev_we;
    logic [GRAN_W-1:0] prev_addr;
    logic [GRAN_W-1:0] prev_data;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] addr;
  } result_t;

endpackage

@@ rtl/core/ffha_ram.sv @@
module ffha_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 14,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/ffha_ctrl.sv @@
`include "first_fit_heap_allocator_macros.svh"

module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [BYTE_W-1:0]   request_bytes_i,
  input  logic [BYTE_W-1:0]   block_address_i,
  input  hdr_t                rd_hdr_i,
  input  logic [GRAN_W-1:0]   rd_prev_i,
  output mem_req_t            mem_req_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output result_t             res_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_FHDR  = 4'd4;
  localparam logic [3:0] S_FNEXT = 4'd5;
  localparam logic [3:0] S_FPREV = 4'd6;
  localparam logic [3:0] S_FWRG  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [GRAN_W-1:0]  clr_q, clr_d;
  logic [GRAN_W1-1:0] need_q, need_d;
  logic [GRAN_W-1:0]  g_q, g_d;
  logic [GRAN_W-1:0]  len_q, len_d;
  logic [GRAN_W-1:0]  prv_q, prv_d;
  logic [GRAN_W1-1:0] nxt_q, nxt_d;
  logic [GRAN_W-1:0]  split_q, split_d;
  logic [GRAN_W-1:0]  slen_q, slen_d;
  logic               keep_q, keep_d;
  result_t            res_q, res_d;

  logic [BYTE_W:0]    need_sum;
  logic [GRAN_W1-1:0] need_in;
  logic [BYTE_W-1:0]  addr_gran;
  logic [BYTE_W-1:0]  free_g;
  logic               addr_bad;
  logic [GRAN_W1-1:0] walk_next;
  logic               walk_fit;
  logic [GRAN_W-1:0]  walk_rem;
  logic [GRAN_W-1:0]  split_at;
  logic [BYTE_W-1:0]  pay_gran;
  logic [GRAN_W1-1:0] hdr_next;
  logic [GRAN_W-1:0]  nm_len;
  logic [GRAN_W1-1:0] nm_after;
  logic [GRAN_W-1:0]  pm_len;
  logic [GRAN_W1-1:0] pm_after;

  // Request size in granules, rounded up.
  assign need_sum  = {1'b0, request_bytes_i} + (BYTE_W + 1)'(GRANULE_BYTES - 1);
  assign need_in   = GRAN_W1'(need_sum >> GOFF_W);

  assign addr_gran = block_address_i >> GOFF_W;
  assign free_g    = addr_gran - BYTE_W'(1);
  assign addr_bad  = (block_address_i[GOFF_W-1:0] != '0)
                  || (block_address_i < BYTE_W'(GRANULE_BYTES))
                  || (free_g >= BYTE_W'(HEAP_GRANULES));

  assign walk_next = GRAN_W1'(g_q) + GRAN_W1'(1) + GRAN_W1'(rd_hdr_i.len);
  assign walk_fit  = !rd_hdr_i.used && (GRAN_W1'(rd_hdr_i.len) >= need_q);
  assign walk_rem  = rd_hdr_i.len - need_q[GRAN_W-1:0];
  assign split_at  = g_q + GRAN_W'(1) + need_q[GRAN_W-1:0];
  assign pay_gran  = BYTE_W'(GRAN_W1'(g_q) + GRAN_W1'(1));

  assign hdr_next  = walk_next;
  assign nm_len    = len_q + rd_hdr_i.len + GRAN_W'(1);
  assign nm_after  = nxt_q + GRAN_W1'(1) + GRAN_W1'(rd_hdr_i.len);
  assign pm_len    = rd_hdr_i.len + len_q + GRAN_W'(1);
  assign pm_after  = GRAN_W1'(prv_q) + GRAN_W1'(1) + GRAN_W1'(pm_len);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    need_d    = need_q;
    g_d       = g_q;
    len_d     = len_q;
    prv_d     = prv_q;
    nxt_d     = nxt_q;
    split_d   = split_q;
    slen_d    = slen_q;
    keep_d    = keep_q;
    res_d     = res_q;
    mem_req_o = '0;

    unique case (state_q)
      S_CLR: begin
        mem_req_o.hdr_we    = 1'b1;
        mem_req_o.hdr_addr  = clr_q;
        mem_req_o.prev_we   = 1'b1;
        mem_req_o.prev_addr = clr_q;
        if (clr_q == '0) begin
          mem_req_o.hdr_data.mark = 1'b1;
          mem_req_o.hdr_data.len  = GRAN_W'(HEAP_GRANULES - 1);
        end
        clr_d = clr_q + GRAN_W'(1);
        if (clr_q == GRAN_W'(HEAP_GRANULES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.status = ST_OK;
          res_d.addr   = '0;
          if (op_i == OP_ALLOC) begin
            need_d = need_in;
            g_d    = '0;
            state_d = S_WALK;
          end else if (block_address_i == '0) begin
            res_d.status = ST_NULL;
            state_d      = S_DONE;
          end else if (addr_bad) begin
            res_d.status = ST_NOT_BLOCK;
            state_d      = S_DONE;
          end else begin
            g_d               = GRAN_W'(free_g);
            mem_req_o.rd_addr = GRAN_W'(free_g);
            state_d           = S_FHDR;
          end
        end
      end
      S_WALK: begin
        if (walk_fit) begin
          res_d.status = ST_OK;
          res_d.addr   = pay_gran << GOFF_W;
          mem_req_o.hdr_we        = 1'b1;
          mem_req_o.hdr_addr      = g_q;
          mem_req_o.hdr_data.mark = 1'b1;
          mem_req_o.hdr_data.used = 1'b1;
          if (walk_rem != '0) begin
            mem_req_o.hdr_data.len = need_q[GRAN_W-1:0];
            split_d = split_at;
            slen_d  = walk_rem - GRAN_W'(1);
            if (walk_next < GRAN_W1'(HEAP_GRANULES)) begin
              mem_req_o.prev_we   = 1'b1;
              mem_req_o.prev_addr = walk_next[GRAN_W-1:0];
              mem_req_o.prev_data = split_at;
            end
            state_d = S_SPLIT;
          end else begin
            mem_req_o.hdr_data.len = rd_hdr_i.len;
            state_d = S_DONE;
          end
        end else if (walk_next >= GRAN_W1'(HEAP_GRANULES)) begin
          res_d.status = ST_OOM;
          res_d.addr   = '0;
          state_d      = S_DONE;
        end else begin
          g_d               = walk_next[GRAN_W-1:0];
          mem_req_o.rd_addr = walk_next[GRAN_W-1:0];
        end
      end
      S_SPLIT: begin
        mem_req_o.hdr_we        = 1'b1;
        mem_req_o.hdr_addr      = split_q;
        mem_req_o.hdr_data.mark = 1'b1;
        mem_req_o.hdr_data.used = 1'b0;
        mem_req_o.hdr_data.len  = slen_q;
        mem_req_o.prev_we       = 1'b1;
        mem_req_o.prev_addr     = split_q;
        mem_req_o.prev_data     = g_q;
        state_d = S_DONE;
      end
      S_FHDR: begin
        if (!rd_hdr_i.mark) begin
          res_d.status = ST_NOT_BLOCK;
          state_d      = S_DONE;
        end else if (!rd_hdr_i.used) begin
          res_d.status = ST_ALREADY_FREE;
          state_d      = S_DONE;
        end else begin
          len_d = rd_hdr_i.len;
          prv_d = rd_prev_i;
          nxt_d = hdr_next;
          if (hdr_next < GRAN_W1'(HEAP_GRANULES)) begin
            mem_req_o.rd_addr = hdr_next[GRAN_W-1:0];
            state_d = S_FNEXT;
          end else if (g_q != '0) begin
            mem_req_o.rd_addr = rd_prev_i;
            state_d = S_FPREV;
          end else begin
            keep_d  = 1'b1;
            state_d = S_FWRG;
          end
        end
      end
      S_FNEXT: begin
        // Absorb a free follower: its header loses the start mark.
        if (!rd_hdr_i.used) begin
          len_d = nm_len;
          mem_req_o.hdr_we        = 1'b1;
          mem_req_o.hdr_addr      = nxt_q[GRAN_W-1:0];
          mem_req_o.hdr_data.mark = 1'b0;
          mem_req_o.hdr_data.used = 1'b0;
          mem_req_o.hdr_data.len  = rd_hdr_i.len;
          if (nm_after < GRAN_W1'(HEAP_GRANULES)) begin
            mem_req_o.prev_we   = 1'b1;
            mem_req_o.prev_addr = nm_after[GRAN_W-1:0];
            mem_req_o.prev_data = g_q;
          end
        end
        if (g_q != '0) begin
          mem_req_o.rd_addr = prv_q;
          state_d = S_FPREV;
        end else begin
          keep_d  = 1'b1;
          state_d = S_FWRG;
        end
      end
      S_FPREV: begin
        if (!rd_hdr_i.used) begin
          mem_req_o.hdr_we        = 1'b1;
          mem_req_o.hdr_addr      = prv_q;
          mem_req_o.hdr_data.mark = 1'b1;
          mem_req_o.hdr_data.used = 1'b0;
          mem_req_o.hdr_data.len  = pm_len;
          if (pm_after < GRAN_W1'(HEAP_GRANULES)) begin
            mem_req_o.prev_we   = 1'b1;
            mem_req_o.prev_addr = pm_after[GRAN_W-1:0];
            mem_req_o.prev_data = prv_q;
          end
          keep_d = 1'b0;
        end else begin
          keep_d = 1'b1;
        end
        state_d = S_FWRG;
      end
      S_FWRG: begin
        mem_req_o.hdr_we        = 1'b1;
        mem_req_o.hdr_addr      = g_q;
        mem_req_o.hdr_data.mark = keep_q;
        mem_req_o.hdr_data.used = 1'b0;
        mem_req_o.hdr_data.len  = len_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    g_q     <= g_d;
    len_q   <= len_d;
    prv_q   <= prv_d;
    nxt_q   <= nxt_d;
    split_q <= split_d;
    slen_q  <= slen_d;
    keep_q  <= keep_d;
    res_q   <= res_d;
  end

  `FFHA_ASSERT(prev_below_hdr, (state_q == S_FPREV) |-> (prv_q < g_q), "back link not below block")
  `FFHA_ASSERT(split_above_hdr, (state_q == S_SPLIT) |-> (split_q > g_q), "split header not above block")
  `FFHA_ASSERT(next_above_hdr, (state_q == S_FNEXT) |-> (nxt_q > GRAN_W1'(g_q)), "follower not above block")
  `FFHA_ASSERT_NEXT(clear_ends_idle, (state_q == S_CLR) && (clr_q == GRAN_W'(HEAP_GRANULES - 1)), state_q == S_IDLE, "clear pass did not end")

endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// Allocate: the blocks are walked in address order, one block per cycle (bounded by the
// memory read loop), and a free remainder is split off in S_SPLIT before the result is
// ready; free checks the header in S_FHDR, merges in S_FNEXT and S_FPREV, writes in S_FWRG.
// Throughput: one word at a time; the next word is taken once the result leaves the
// sequencer, so the rate is set by the first-fit walk over the header memory.
// Reset: asynchronous, active low; a clearing pass over all 4096 granules rebuilds the single free
// block before the first word is accepted.
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [BYTE_W-1:0]   request_bytes_i,
  input  logic [BYTE_W-1:0]   block_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   payload_address_o
);

  // The heap state lives in two memories indexed by granule. The header memory holds
  // the start mark, the in-use bit and the payload length of each block; the back-link
  // memory holds the header granule of the preceding block. Both have one write port and
  // one read port with a registered read, shared by the same read address.
  //
  // The sequencer issues each read in the state before the one that consumes it. Writes
  // to a block never coincide with a read of the same entry that is still needed, because
  // every write follows the read it depends on, so no forwarding path is required.

  mem_req_t          mem_req;
  hdr_t              rd_hdr;
  logic [GRAN_W-1:0] rd_prev;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  ffha_ram #(
    .DEPTH (HEAP_GRANULES),
    .WIDTH (HDR_W)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.hdr_we),
    .waddr_i (mem_req.hdr_addr),
    .wdata_i (mem_req.hdr_data),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (rd_hdr)
  );

  ffha_ram #(
    .DEPTH (HEAP_GRANULES),
    .WIDTH (GRAN_W)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.prev_we),
    .waddr_i (mem_req.prev_addr),
    .wdata_i (mem_req.prev_data),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (rd_prev)
  );

  ffha_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .request_bytes_i (request_bytes_i),
    .block_address_i (block_address_i),
    .rd_hdr_i        (rd_hdr),
    .rd_prev_i       (rd_prev),
    .mem_req_o       (mem_req),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Output register: the sequencer hands its result over whenever the slot is empty or
  // is being emptied in the same cycle; while a stalled consumer leaves the slot full, it waits.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign payload_address_o = out_q.addr;

  // Only one word is in the sequencer at a time.
  `FFHA_ASSERT_NEXT(one_word_in_flight, in_valid_i && in_ready_o, !in_ready_o, "word taken while busy")

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import ffha_pkg::*;

  // Random words after the directed opening.
  localparam int unsigned RANDOM_WORDS = 1650;
  // Live allocations are capped so that the heap never holds more than about
  // twice this many blocks, which keeps the first-fit walk short.
  localparam int unsigned LIVE_LIMIT = 40;
  // Freed addresses kept around to be freed a second time.
  localparam int unsigned RETIRED_KEEP = 16;

  // One input word as the driver presents it.
  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] bytes;
    logic [BYTE_W-1:0] addr;
  } heap_word_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                op_i              = OP_ALLOC;
  logic [BYTE_W-1:0]   request_bytes_i   = '0;
  logic [BYTE_W-1:0]   block_address_i   = '0;
  logic                out_ready_i       = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [BYTE_W-1:0]   payload_address_o;

  first_fit_heap_allocator DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .payload_address_o (payload_address_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the heap bookkeeping, one entry per granule. Only entries
  // with the start mark set describe a block.
  logic              heap_mark [HEAP_GRANULES];
  logic              heap_used [HEAP_GRANULES];
  logic [GRAN_W-1:0] heap_len  [HEAP_GRANULES];
  logic [GRAN_W-1:0] heap_prev [HEAP_GRANULES];

  heap_word_t        pending_words[$];
  result_t           expected_results[$];
  logic [BYTE_W-1:0] live_blocks[$];
  logic [BYTE_W-1:0] retired_blocks[$];

  int          mismatch_count = 0;
  bit          word_taken     = 1'b0;
  bit          quiet_stretch  = 1'b0;
  int          idle_left      = 0;
  int          burst_left     = 0;
  logic [15:0] stall_mask     = 16'hFFFF;
  logic [3:0]  stall_pos      = '0;

  // Applies one word to the shadow heap and returns the result the allocator
  // must give for it.
  function automatic void heap_step(input heap_word_t w, output result_t res);
    int need;
    int g;
    int s;
    int n;
    int p;
    int steps;
    bit found;
    res.status = ST_OK;
    res.addr   = '0;
    if (w.op == OP_ALLOC) begin
      need  = (int'(w.bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES;
      g     = 0;
      steps = 0;
      found = 1'b0;
      // First fit: walk the blocks in address order.
      while (g < HEAP_GRANULES && steps < HEAP_GRANULES && !found) begin
        if (!heap_used[g] && int'(heap_len[g]) >= need) begin
          found = 1'b1;
        end else begin
          g     = g + 1 + int'(heap_len[g]);
          steps = steps + 1;
        end
      end
      if (!found) begin
        res.status = ST_OOM;
      end else begin
        // Any granule left over becomes the header of a new free block.
        if (int'(heap_len[g]) - need >= 1) begin
          s            = g + 1 + need;
          heap_mark[s] = 1'b1;
          heap_used[s] = 1'b0;
          heap_len[s]  = GRAN_W'(int'(heap_len[g]) - need - 1);
          heap_prev[s] = GRAN_W'(g);
          n            = s + 1 + int'(heap_len[s]);
          if (n < HEAP_GRANULES) heap_prev[n] = GRAN_W'(s);
          heap_len[g]  = GRAN_W'(need);
        end
        heap_used[g] = 1'b1;
        // The payload of the very last granule wraps to address zero.
        res.addr = BYTE_W'((g + 1) * GRANULE_BYTES);
      end
    end else if (w.addr == '0) begin
      res.status = ST_NULL;
    end else if ((w.addr % GRANULE_BYTES) != 0 || w.addr < GRANULE_BYTES) begin
      res.status = ST_NOT_BLOCK;
    end else begin
      g = int'(w.addr) / GRANULE_BYTES - 1;
      if (g >= HEAP_GRANULES || !heap_mark[g]) begin
        res.status = ST_NOT_BLOCK;
      end else if (!heap_used[g]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        heap_used[g] = 1'b0;
        // Absorb a free block that follows.
        n = g + 1 + int'(heap_len[g]);
        if (n < HEAP_GRANULES && !heap_used[n]) begin
          heap_len[g]  = GRAN_W'(int'(heap_len[g]) + int'(heap_len[n]) + 1);
          heap_mark[n] = 1'b0;
          n            = g + 1 + int'(heap_len[g]);
          if (n < HEAP_GRANULES) heap_prev[n] = GRAN_W'(g);
        end
        // Then let a free block in front absorb this one.
        p = int'(heap_prev[g]);
        if (g != 0 && p < HEAP_GRANULES && !heap_used[p]) begin
          heap_len[p]  = GRAN_W'(int'(heap_len[p]) + int'(heap_len[g]) + 1);
          heap_mark[g] = 1'b0;
          n            = p + 1 + int'(heap_len[p]);
          if (n < HEAP_GRANULES) heap_prev[n] = GRAN_W'(p);
        end
      end
    end
  endfunction

  // Hands one word to the driver once the previous one has been taken, so
  // that the live list the stimulus draws from is always up to date.
  task automatic send_word(input logic op, input logic [BYTE_W-1:0] bytes,
                           input logic [BYTE_W-1:0] addr);
    heap_word_t w;
    while (pending_words.size() != 0) @(posedge clk_i);
    w.op    = op;
    w.bytes = bytes;
    w.addr  = addr;
    pending_words.push_back(w);
  endtask

  // Input side: a word is presented at the falling edge and held until the
  // rising edge that takes it. Bursts of random length alternate with random
  // gaps, except during quiet stretches.
  always @(negedge clk_i) begin
    if (!in_valid_i || word_taken) begin
      word_taken = 1'b0;
      if (idle_left > 0 && !quiet_stretch) begin
        idle_left = idle_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_valid_i      <= 1'b1;
        op_i            <= pending_words[0].op;
        request_bytes_i <= pending_words[0].bytes;
        block_address_i <= pending_words[0].addr;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 15);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: ready follows a rotating 16-bit mask that is drawn anew on
  // each turn, mostly open but now and then mostly closed.
  always @(negedge clk_i) begin
    out_ready_i <= quiet_stretch | stall_mask[stall_pos];
    if (stall_pos == 4'd15) begin
      if ($urandom_range(0, 3) == 0) stall_mask = 16'($urandom() & $urandom());
      else stall_mask = 16'($urandom() | $urandom());
    end
    stall_pos = stall_pos + 4'd1;
  end

  // Rising edge: predict each accepted word, then check each delivered result
  // against the oldest expectation.
  always @(posedge clk_i) begin
    heap_word_t w;
    result_t    res;
    result_t    want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      w = pending_words.pop_front();
      heap_step(w, res);
      expected_results.push_back(res);
      word_taken = 1'b1;
      // Keep the stimulus lists in step with the heap.
      if (w.op == OP_ALLOC && res.status == ST_OK && res.addr != '0) begin
        live_blocks.push_back(res.addr);
      end else if (w.op == OP_FREE && res.status == ST_OK) begin
        for (int k = live_blocks.size() - 1; k >= 0; k--) begin
          if (live_blocks[k] == w.addr) live_blocks.delete(k);
        end
        retired_blocks.push_back(w.addr);
        if (retired_blocks.size() > RETIRED_KEEP) void'(retired_blocks.pop_front());
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, payload_address %0h",
               status_o, payload_address_o);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count = mismatch_count + 1;
        end
        if (payload_address_o !== want.addr) begin
          $error("payload_address: expected %0h, got %0h", want.addr, payload_address_o);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  initial begin
    int                kind;
    int                pick;
    logic [BYTE_W-1:0] bytes;
    logic [BYTE_W-1:0] addr;

    // The heap after reset is one free block spanning every granule.
    for (int g = 0; g < HEAP_GRANULES; g++) begin
      heap_mark[g] = 1'b0;
      heap_used[g] = 1'b0;
      heap_len[g]  = '0;
      heap_prev[g] = '0;
    end
    heap_mark[0] = 1'b1;
    heap_len[0]  = GRAN_W'(HEAP_GRANULES - 1);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. Carve four small blocks: an empty payload, one
    // granule from one byte, one granule exactly, two granules from 17 bytes.
    send_word(OP_ALLOC, 16'd0, 16'($urandom()));
    send_word(OP_ALLOC, 16'd1, 16'($urandom()));
    send_word(OP_ALLOC, 16'd16, 16'($urandom()));
    send_word(OP_ALLOC, 16'd17, 16'($urandom()));
    // Bad frees: null, below one granule, misaligned, inside a block.
    send_word(OP_FREE, 16'($urandom()), 16'd0);
    send_word(OP_FREE, 16'($urandom()), 16'd8);
    send_word(OP_FREE, 16'($urandom()), 16'd33);
    send_word(OP_FREE, 16'($urandom()), 16'd48);
    // Free, double free, a free that merges backwards, then the merged
    // header, which is no longer a block.
    send_word(OP_FREE, 16'($urandom()), 16'd32);
    send_word(OP_FREE, 16'($urandom()), 16'd32);
    send_word(OP_FREE, 16'($urandom()), 16'd64);
    send_word(OP_FREE, 16'($urandom()), 16'd64);
    // Merges forwards, then on both sides, back to a single free block.
    send_word(OP_FREE, 16'($urandom()), 16'd16);
    send_word(OP_FREE, 16'($urandom()), 16'd96);
    // Too large, the whole heap exactly, nothing left, and back.
    send_word(OP_ALLOC, 16'hFFFF, 16'($urandom()));
    send_word(OP_ALLOC, 16'd65520, 16'($urandom()));
    send_word(OP_ALLOC, 16'd0, 16'($urandom()));
    send_word(OP_FREE, 16'($urandom()), 16'd16);
    // Leave a lone header in the last granule and take it: its payload
    // address wraps to zero, so it stays allocated for the rest of the run.
    send_word(OP_ALLOC, 16'd65504, 16'($urandom()));
    send_word(OP_ALLOC, 16'd0, 16'($urandom()));
    send_word(OP_ALLOC, 16'd0, 16'($urandom()));
    send_word(OP_FREE, 16'($urandom()), 16'd65520);
    send_word(OP_FREE, 16'($urandom()), 16'hFFFF);
    send_word(OP_FREE, 16'($urandom()), 16'd16);

    // Random part: mostly allocations and frees of live blocks, with double
    // frees, stray addresses, null and misaligned frees mixed in.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      while (pending_words.size() != 0) @(posedge clk_i);
      quiet_stretch = (i % 400) < 60;
      kind = $urandom_range(0, 99);
      if (live_blocks.size() >= LIVE_LIMIT) kind = 60;
      if (kind < 45 || (kind < 85 && live_blocks.size() == 0)) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) bytes = 16'($urandom_range(0, 64));
        else if (pick < 85) bytes = 16'($urandom_range(65, 1024));
        else if (pick < 95) bytes = 16'($urandom_range(1025, 8192));
        else bytes = 16'($urandom());
        send_word(OP_ALLOC, bytes, 16'($urandom()));
      end else begin
        if (kind < 85) begin
          addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        end else if (kind < 90 && retired_blocks.size() != 0) begin
          addr = retired_blocks[$urandom_range(0, retired_blocks.size() - 1)];
        end else if (kind < 95) begin
          addr = 16'($urandom());
        end else if (kind < 97) begin
          addr = '0;
        end else if (live_blocks.size() != 0) begin
          addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                 + 16'($urandom_range(1, GRANULE_BYTES - 1));
        end else begin
          addr = 16'($urandom());
        end
        send_word(OP_FREE, 16'($urandom()), addr);
      end
    end

    // Drain, then keep watching the output for anything stray before the verdict.
    quiet_stretch = 1'b1;
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run including the clearing pass.
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ first_fit_heap_allocator.f @@
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
sim/tb_top.sv
